/* hdl/pdc_pkg.sv */
`timescale 1ns / 1ps

package pdc_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_OPENING = 3'd1,
      MODE_WAITING = 3'd2,
      MODE_OPEN    = 3'd3,
      MODE_CLOSING = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_OPEN  = 2'd1,
      OP_CLOSE = 2'd2
   } op_type;

   localparam logic [1:0] MOTOR_NONE = 2'd0;
   localparam logic [1:0] MOTOR_UP   = 2'd1;
   localparam logic [1:0] MOTOR_DOWN = 2'd2;
   localparam logic [1:0] MOTOR_STOP = 2'd3;

   localparam logic [1:0] NOTIFY_NONE   = 2'd0;
   localparam logic [1:0] NOTIFY_OPENED = 2'd1;
   localparam logic [1:0] NOTIFY_CLOSED = 2'd2;
   localparam logic [1:0] NOTIFY_LOCKED = 2'd3;

   localparam logic [1:0] STATUS_NONE     = 2'd0;
   localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
   localparam logic [1:0] STATUS_BUSY     = 2'd2;
   localparam logic [1:0] STATUS_THERE    = 2'd3;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OPEN_RSSI      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLOSE_RSSI     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TRAVEL_MS      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BEACON_TIMEOUT = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WAIT_TIMEOUT   = 3'd4;

   localparam logic signed [7:0] OPEN_RSSI_RESET      = -8'sd75;
   localparam logic signed [7:0] CLOSE_RSSI_RESET     = -8'sd90;
   localparam logic [15:0]       TRAVEL_MS_RESET      = 16'd10000;
   localparam logic [15:0]       BEACON_TIMEOUT_RESET = 16'd2000;
   localparam logic [15:0]       WAIT_TIMEOUT_RESET   = 16'd5000;
   localparam logic signed [7:0] LAST_RSSI_RESET      = -8'sd100;

endpackage

/* hdl/pdc_req_if.sv */
`timescale 1ns / 1ps

interface pdc_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        operation;
   logic [15:0]       elapsed_ms;
   logic              beacon_found;
   logic signed [7:0] beacon_rssi;
   logic              path_clear;
   logic              pet_passed;

   modport source (
      output valid, operation, elapsed_ms, beacon_found, beacon_rssi, path_clear,
             pet_passed,
      input  ready
   );

   modport sink (
      input  valid, operation, elapsed_ms, beacon_found, beacon_rssi, path_clear,
             pet_passed,
      output ready
   );
endinterface

/* hdl/pdc_rsp_if.sv */
`timescale 1ns / 1ps

interface pdc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  door_mode;
   logic [15:0] position_out;
   logic [1:0]  motor_drive;
   logic        moving_out;
   logic [1:0]  notify;
   logic        confirm_open;
   logic        confirm_closed;
   logic [1:0]  command_status;
   logic        clear_pet_flag;

   modport source (
      output valid, door_mode, position_out, motor_drive, moving_out, notify,
             confirm_open, confirm_closed, command_status, clear_pet_flag,
      input  ready
   );

   modport sink (
      input  valid, door_mode, position_out, motor_drive, moving_out, notify,
             confirm_open, confirm_closed, command_status, clear_pet_flag,
      output ready
   );
endinterface

/* hdl/proximity_door_controller.sv */
`timescale 1ns / 1ps

// Motorized door controller driven by tick and remote command requests. Each request
// gives exactly one response, in order. A request is captured in an input register
// and resolved against the door state into the response register, so the block takes
// one request per clock while the response is taken; it holds off requests only while
// both registers are full and the response is not taken. The user must write the
// configuration registers through the csr port while no request is in flight; the block
// itself does not enforce this. They take effect on the next request.
module proximity_door_controller
   import pdc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   pdc_req_if.sink                    req_chan,
   pdc_rsp_if.source                  rsp_chan,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   logic signed [7:0] open_rssi_ff;
   logic signed [7:0] close_rssi_ff;
   logic [15:0]       travel_ff;
   logic [15:0]       beacon_timeout_ff;
   logic [15:0]       wait_timeout_ff;

   logic              in_valid_ff;
   logic [1:0]        in_op_ff;
   logic [15:0]       in_dt_ff;
   logic              in_found_ff;
   logic signed [7:0] in_rssi_ff;
   logic              in_clear_ff;
   logic              in_pet_ff;

   mode_type          mode_ff, mode_in;
   logic [15:0]       position_ff, position_in;
   logic signed [7:0] last_rssi_ff, last_rssi_in;
   logic [15:0]       beacon_age_ff, beacon_age_in;
   logic [15:0]       wait_age_ff, wait_age_in;
   logic              override_ff, override_in;
   logic              moving_ff, moving_in;
   logic              pending_ff, pending_in;
   logic              is_close_ff, is_close_in;

   logic              out_valid_ff;
   logic [2:0]        out_mode_ff;
   logic [15:0]       out_position_ff;
   logic [1:0]        out_motor_ff, motor_in;
   logic              out_moving_ff;
   logic [1:0]        out_notify_ff, notify_in;
   logic              out_c_open_ff, c_open_in;
   logic              out_c_closed_ff, c_closed_in;
   logic [1:0]        out_status_ff, status_in;
   logic              out_clr_pet_ff, clr_pet_in;

   logic              advance;
   logic              is_tick, is_open_cmd, is_close_cmd;
   logic signed [7:0] rssi_now;
   logic [15:0]       beacon_age_tick, wait_age_tick;
   logic [15:0]       open_pos, close_pos;
   logic              open_done, close_done;
   logic              idle_start, wait_leave;
   logic              busy, open_there, close_there;

   function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_rssi_ff      <= OPEN_RSSI_RESET;
         close_rssi_ff     <= CLOSE_RSSI_RESET;
         travel_ff         <= TRAVEL_MS_RESET;
         beacon_timeout_ff <= BEACON_TIMEOUT_RESET;
         wait_timeout_ff   <= WAIT_TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_OPEN_RSSI:      open_rssi_ff      <= csr_write_data[7:0];
            CSR_CLOSE_RSSI:     close_rssi_ff     <= csr_write_data[7:0];
            CSR_TRAVEL_MS:      travel_ff         <= csr_write_data;
            CSR_BEACON_TIMEOUT: beacon_timeout_ff <= csr_write_data;
            CSR_WAIT_TIMEOUT:   wait_timeout_ff   <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // capture request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_op_ff    <= req_chan.operation;
         in_dt_ff    <= req_chan.elapsed_ms;
         in_found_ff <= req_chan.beacon_found;
         in_rssi_ff  <= req_chan.beacon_rssi;
         in_clear_ff <= req_chan.path_clear;
         in_pet_ff   <= req_chan.pet_passed;
      end
   end

   assign is_tick         = in_op_ff == OP_TICK;
   assign is_open_cmd     = in_op_ff == OP_OPEN;
   assign is_close_cmd    = in_op_ff == OP_CLOSE;
   assign rssi_now        = in_found_ff ? in_rssi_ff : last_rssi_ff;
   assign beacon_age_tick = in_found_ff ? 16'd0 : sat_add16(beacon_age_ff, in_dt_ff);
   assign wait_age_tick   = sat_add16(wait_age_ff, in_dt_ff);
   assign open_pos        = sat_add16(position_ff, in_dt_ff);
   assign open_done       = open_pos >= travel_ff;
   assign close_pos       = (position_ff > in_dt_ff) ? (position_ff - in_dt_ff) : 16'd0;
   assign close_done      = close_pos == 16'd0;
   assign idle_start      = in_found_ff && (in_rssi_ff >= open_rssi_ff);
   assign wait_leave      = in_pet_ff || (beacon_age_tick > beacon_timeout_ff) ||
                            (rssi_now < close_rssi_ff) || (wait_age_tick >= wait_timeout_ff);
   assign busy            = (mode_ff == MODE_OPENING) || (mode_ff == MODE_CLOSING);
   assign open_there      = (mode_ff == MODE_OPEN) ||
                            ((mode_ff == MODE_WAITING) && (position_ff >= travel_ff));
   assign close_there     = (mode_ff == MODE_IDLE) && (position_ff == 16'd0);

   // next mode
   always_comb begin
      mode_in = mode_ff;
      if (is_tick) begin
         unique case (mode_ff)
            MODE_IDLE: begin
               if (idle_start) mode_in = MODE_OPENING;
            end
            MODE_OPENING: begin
               if (open_done) mode_in = override_ff ? MODE_OPEN : MODE_WAITING;
            end
            MODE_WAITING: begin
               if (override_ff) mode_in = MODE_OPEN;
               else if (wait_leave) mode_in = MODE_CLOSING;
            end
            MODE_CLOSING: begin
               if (!in_clear_ff) mode_in = MODE_OPENING;
               else if (close_done) mode_in = MODE_IDLE;
            end
            default: begin
            end
         endcase
      end else if (is_open_cmd && !busy && !open_there) begin
         mode_in = MODE_OPENING;
      end else if (is_close_cmd && !busy && !close_there) begin
         mode_in = MODE_CLOSING;
      end
   end

   // datapath and events
   always_comb begin
      position_in  = position_ff;
      last_rssi_in = last_rssi_ff;
      beacon_age_in = beacon_age_ff;
      wait_age_in  = wait_age_ff;
      override_in  = override_ff;
      moving_in    = moving_ff;
      pending_in   = pending_ff;
      is_close_in  = is_close_ff;
      motor_in     = MOTOR_NONE;
      notify_in    = NOTIFY_NONE;
      c_open_in    = 1'b0;
      c_closed_in  = 1'b0;
      status_in    = STATUS_NONE;
      clr_pet_in   = 1'b0;
      if (is_tick) begin
         last_rssi_in  = rssi_now;
         beacon_age_in = beacon_age_tick;
         if (mode_ff == MODE_WAITING) wait_age_in = wait_age_tick;
         unique case (mode_ff)
            MODE_IDLE: begin
               position_in = 16'd0;
               if (idle_start) begin
                  clr_pet_in = 1'b1;
                  moving_in  = 1'b1;
                  motor_in   = MOTOR_UP;
               end
            end
            MODE_OPENING: begin
               if (open_done) begin
                  position_in = travel_ff;
                  motor_in    = MOTOR_STOP;
                  moving_in   = 1'b0;
                  notify_in   = NOTIFY_OPENED;
                  if (!override_ff) wait_age_in = 16'd0;
                  if (pending_ff && !is_close_ff) begin
                     c_open_in  = 1'b1;
                     pending_in = 1'b0;
                  end
               end else begin
                  position_in = open_pos;
                  motor_in    = MOTOR_UP;
               end
            end
            MODE_WAITING: begin
               position_in = travel_ff;
               if (override_ff) moving_in = 1'b0;
               else if (wait_leave) moving_in = 1'b1;
            end
            MODE_OPEN: begin
               position_in = travel_ff;
               moving_in   = 1'b0;
            end
            MODE_CLOSING: begin
               if (!in_clear_ff) begin
                  moving_in = 1'b1;
                  motor_in  = MOTOR_UP;
               end else begin
                  position_in = close_pos;
                  if (close_done) begin
                     motor_in  = MOTOR_STOP;
                     moving_in = 1'b0;
                     notify_in = NOTIFY_CLOSED;
                     if (pending_ff && is_close_ff) begin
                        c_closed_in = 1'b1;
                        pending_in  = 1'b0;
                     end
                  end else begin
                     motor_in = MOTOR_DOWN;
                  end
               end
            end
            default: begin
            end
         endcase
      end else if (is_open_cmd || is_close_cmd) begin
         if (busy) begin
            status_in = STATUS_BUSY;
         end else if (is_open_cmd) begin
            if (open_there) begin
               status_in = STATUS_THERE;
            end else begin
               moving_in   = 1'b1;
               override_in = 1'b1;
               motor_in    = MOTOR_UP;
               pending_in  = 1'b1;
               is_close_in = 1'b0;
               status_in   = STATUS_ACCEPTED;
            end
         end else begin
            if (close_there) begin
               status_in = STATUS_THERE;
            end else begin
               moving_in   = 1'b1;
               override_in = 1'b0;
               motor_in    = MOTOR_DOWN;
               pending_in  = 1'b1;
               is_close_in = 1'b1;
               notify_in   = NOTIFY_LOCKED;
               status_in   = STATUS_ACCEPTED;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         position_ff   <= 16'd0;
         last_rssi_ff  <= LAST_RSSI_RESET;
         beacon_age_ff <= 16'd0;
         wait_age_ff   <= 16'd0;
         override_ff   <= 1'b0;
         moving_ff     <= 1'b0;
         pending_ff    <= 1'b0;
         is_close_ff   <= 1'b0;
      end else if (advance) begin
         mode_ff       <= mode_in;
         position_ff   <= position_in;
         last_rssi_ff  <= last_rssi_in;
         beacon_age_ff <= beacon_age_in;
         wait_age_ff   <= wait_age_in;
         override_ff   <= override_in;
         moving_ff     <= moving_in;
         pending_ff    <= pending_in;
         is_close_ff   <= is_close_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_mode_ff     <= mode_in;
         out_position_ff <= position_in;
         out_motor_ff    <= motor_in;
         out_moving_ff   <= moving_in;
         out_notify_ff   <= notify_in;
         out_c_open_ff   <= c_open_in;
         out_c_closed_ff <= c_closed_in;
         out_status_ff   <= status_in;
         out_clr_pet_ff  <= clr_pet_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.door_mode      = out_mode_ff;
   assign rsp_chan.position_out   = out_position_ff;
   assign rsp_chan.motor_drive    = out_motor_ff;
   assign rsp_chan.moving_out     = out_moving_ff;
   assign rsp_chan.notify         = out_notify_ff;
   assign rsp_chan.confirm_open   = out_c_open_ff;
   assign rsp_chan.confirm_closed = out_c_closed_ff;
   assign rsp_chan.command_status = out_status_ff;
   assign rsp_chan.clear_pet_flag = out_clr_pet_ff;

   a_moving_matches_mode: assert property (@(posedge clock) disable iff (reset)
      moving_ff == ((mode_ff == MODE_OPENING) || (mode_ff == MODE_CLOSING)))
      else $error("moving flag disagrees with door mode");

   a_confirm_closed_event: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_c_closed_ff) |->
         (out_notify_ff == NOTIFY_CLOSED) && (out_mode_ff == MODE_IDLE))
      else $error("close confirmation without closed event");

   a_confirm_open_event: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_c_open_ff) |-> (out_notify_ff == NOTIFY_OPENED))
      else $error("open confirmation without opened event");

   a_busy_in_motion: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_status_ff == STATUS_BUSY)) |->
         ((out_mode_ff == MODE_OPENING) || (out_mode_ff == MODE_CLOSING)))
      else $error("busy status while door at rest");

endmodule

/* verif/proximity_door_controller_tb.sv */
`timescale 1ns / 1ps

module proximity_door_controller_tb
   import pdc_pkg::*;
();

   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] elapsed_ms;
      logic        beacon_found;
      logic [7:0]  beacon_rssi;
      logic        path_clear;
      logic        pet_passed;
   } door_request_type;

   typedef struct packed {
      logic [2:0]  door_mode;
      logic [15:0] position_out;
      logic [1:0]  motor_drive;
      logic        moving_out;
      logic [1:0]  notify;
      logic        confirm_open;
      logic        confirm_closed;
      logic [1:0]  command_status;
      logic        clear_pet_flag;
   } door_response_type;

   class door_scoreboard_type;
      logic signed [7:0] open_rssi;
      logic signed [7:0] close_rssi;
      logic [15:0]       travel_ms;
      logic [15:0]       beacon_timeout_ms;
      logic [15:0]       wait_timeout_ms;

      mode_type          mode;
      logic [15:0]       position_ms;
      logic signed [7:0] last_rssi;
      logic [15:0]       beacon_age_ms;
      logic [15:0]       wait_age_ms;
      logic              override_active;
      logic              moving;
      logic              confirm_pending;
      logic              confirm_is_close;

      door_response_type pending_responses[$];
      int                failures;
      int                responses_seen;

      function new();
         open_rssi         = OPEN_RSSI_RESET;
         close_rssi        = CLOSE_RSSI_RESET;
         travel_ms         = TRAVEL_MS_RESET;
         beacon_timeout_ms = BEACON_TIMEOUT_RESET;
         wait_timeout_ms   = WAIT_TIMEOUT_RESET;
         mode              = MODE_IDLE;
         position_ms       = '0;
         last_rssi         = LAST_RSSI_RESET;
         beacon_age_ms     = '0;
         wait_age_ms       = '0;
         override_active   = 1'b0;
         moving            = 1'b0;
         confirm_pending   = 1'b0;
         confirm_is_close  = 1'b0;
         failures          = 0;
         responses_seen    = 0;
      endfunction

      task report(string msg);
         failures++;
         $display("ERROR at %0t: %s", $realtime, msg);
      endtask

      function int pending();
         return pending_responses.size();
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] index,
                              logic [CSR_DATA_WIDTH-1:0] data);
         case (index)
            CSR_OPEN_RSSI:      open_rssi = data[7:0];
            CSR_CLOSE_RSSI:     close_rssi = data[7:0];
            CSR_TRAVEL_MS:      travel_ms = data;
            CSR_BEACON_TIMEOUT: beacon_timeout_ms = data;
            CSR_WAIT_TIMEOUT:   wait_timeout_ms = data;
            default: ;
         endcase
      endfunction

      function logic [15:0] sat_add(logic [15:0] a, logic [15:0] b);
         logic [16:0] sum;
         sum = {1'b0, a} + {1'b0, b};
         return sum[16] ? 16'hFFFF : sum[15:0];
      endfunction

      function door_response_type advance_door(door_request_type rq);
         door_response_type o;
         logic [15:0]    dt;
         logic [1:0]     drive;
         logic [1:0]     event_code;
         logic [1:0]     status;
         logic           c_open;
         logic           c_closed;
         logic           clr_pet;
         dt         = rq.elapsed_ms;
         drive      = MOTOR_NONE;
         event_code = NOTIFY_NONE;
         status     = STATUS_NONE;
         c_open     = 1'b0;
         c_closed   = 1'b0;
         clr_pet    = 1'b0;
         if (rq.operation == OP_TICK) begin
            if (rq.beacon_found) begin
               last_rssi     = rq.beacon_rssi;
               beacon_age_ms = '0;
            end else begin
               beacon_age_ms = sat_add(beacon_age_ms, dt);
            end
            if (mode == MODE_WAITING)
               wait_age_ms = sat_add(wait_age_ms, dt);
            case (mode)
               MODE_IDLE: begin
                  position_ms = '0;
                  if (rq.beacon_found && last_rssi >= open_rssi) begin
                     mode    = MODE_OPENING;
                     clr_pet = 1'b1;
                     moving  = 1'b1;
                     drive   = MOTOR_UP;
                  end
               end
               MODE_OPENING: begin
                  position_ms = sat_add(position_ms, dt);
                  if (position_ms >= travel_ms) begin
                     position_ms = travel_ms;
                     drive       = MOTOR_STOP;
                     moving      = 1'b0;
                     if (override_active) begin
                        mode = MODE_OPEN;
                     end else begin
                        mode        = MODE_WAITING;
                        wait_age_ms = '0;
                     end
                     event_code = NOTIFY_OPENED;
                     if (confirm_pending && !confirm_is_close) begin
                        c_open          = 1'b1;
                        confirm_pending = 1'b0;
                     end
                  end else begin
                     drive = MOTOR_UP;
                  end
               end
               MODE_WAITING: begin
                  position_ms = travel_ms;
                  if (override_active) begin
                     mode   = MODE_OPEN;
                     moving = 1'b0;
                  end else if (rq.pet_passed || beacon_age_ms > beacon_timeout_ms ||
                               last_rssi < close_rssi ||
                               wait_age_ms >= wait_timeout_ms) begin
                     mode   = MODE_CLOSING;
                     moving = 1'b1;
                  end
               end
               MODE_OPEN: begin
                  position_ms = travel_ms;
                  moving      = 1'b0;
               end
               MODE_CLOSING: begin
                  if (!rq.path_clear) begin
                     mode   = MODE_OPENING;
                     moving = 1'b1;
                     drive  = MOTOR_UP;
                  end else begin
                     drive       = MOTOR_DOWN;
                     position_ms = (position_ms > dt) ? position_ms - dt : 16'd0;
                     if (position_ms == 16'd0) begin
                        drive      = MOTOR_STOP;
                        moving     = 1'b0;
                        mode       = MODE_IDLE;
                        event_code = NOTIFY_CLOSED;
                        if (confirm_pending && confirm_is_close) begin
                           c_closed        = 1'b1;
                           confirm_pending = 1'b0;
                        end
                     end
                  end
               end
               default: ;
            endcase
         end else if (rq.operation == OP_OPEN || rq.operation == OP_CLOSE) begin
            if (mode == MODE_OPENING || mode == MODE_CLOSING) begin
               status = STATUS_BUSY;
            end else if (rq.operation == OP_OPEN) begin
               if (mode == MODE_OPEN ||
                   (mode == MODE_WAITING && position_ms >= travel_ms)) begin
                  status = STATUS_THERE;
               end else begin
                  mode             = MODE_OPENING;
                  moving           = 1'b1;
                  override_active  = 1'b1;
                  drive            = MOTOR_UP;
                  confirm_pending  = 1'b1;
                  confirm_is_close = 1'b0;
                  status           = STATUS_ACCEPTED;
               end
            end else begin
               if (mode == MODE_IDLE && position_ms == 16'd0) begin
                  status = STATUS_THERE;
               end else begin
                  mode             = MODE_CLOSING;
                  moving           = 1'b1;
                  override_active  = 1'b0;
                  drive            = MOTOR_DOWN;
                  confirm_pending  = 1'b1;
                  confirm_is_close = 1'b1;
                  event_code       = NOTIFY_LOCKED;
                  status           = STATUS_ACCEPTED;
               end
            end
         end
         o.door_mode      = mode;
         o.position_out   = position_ms;
         o.motor_drive    = drive;
         o.moving_out     = moving;
         o.notify         = event_code;
         o.confirm_open   = c_open;
         o.confirm_closed = c_closed;
         o.command_status = status;
         o.clear_pet_flag = clr_pet;
         return o;
      endfunction

      function void note_request(door_request_type rq);
         pending_responses.push_back(advance_door(rq));
      endfunction

      task compare_field(string name, int got, int want);
         if (got != want)
            report($sformatf("response %0d: %s is %0d, expected %0d",
                             responses_seen, name, got, want));
      endtask

      task check_response(door_response_type got);
         door_response_type want;
         if (pending_responses.size() == 0) begin
            report($sformatf("response %0d arrived with no request outstanding",
                             responses_seen));
         end else begin
            want = pending_responses.pop_front();
            compare_field("door_mode", got.door_mode, want.door_mode);
            compare_field("position_out", got.position_out, want.position_out);
            compare_field("motor_drive", got.motor_drive, want.motor_drive);
            compare_field("moving_out", got.moving_out, want.moving_out);
            compare_field("notify", got.notify, want.notify);
            compare_field("confirm_open", got.confirm_open, want.confirm_open);
            compare_field("confirm_closed", got.confirm_closed, want.confirm_closed);
            compare_field("command_status", got.command_status, want.command_status);
            compare_field("clear_pet_flag", got.clear_pet_flag, want.clear_pet_flag);
         end
         responses_seen++;
      endtask
   endclass

   logic                       clock;
   logic                       reset;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   pdc_req_if req_chan ();
   pdc_rsp_if rsp_chan ();

   proximity_door_controller DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   door_scoreboard_type door = new();

   bit          steady;
   int          burst_left;
   int          hold_off_cycles;
   logic [15:0] cur_travel;
   int          cur_open;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   function int pick_gap();
      int k;
      k = $urandom_range(0, 99);
      if (steady || k < 60)
         return 0;
      else if (k < 90)
         return $urandom_range(1, 3);
      else if (k < 98)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
            door.note_request({req_chan.operation, req_chan.elapsed_ms,
                               req_chan.beacon_found, req_chan.beacon_rssi,
                               req_chan.path_clear, req_chan.pet_passed});
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
            door.check_response({rsp_chan.door_mode, rsp_chan.position_out,
                                 rsp_chan.motor_drive, rsp_chan.moving_out,
                                 rsp_chan.notify, rsp_chan.confirm_open,
                                 rsp_chan.confirm_closed, rsp_chan.command_status,
                                 rsp_chan.clear_pet_flag});
      end
   end

   // response side: random stalls, plus a long hold-off on request
   initial begin
      int n;
      int stall;
      rsp_chan.ready = 1'b0;
      forever begin
         if (hold_off_cycles != 0) begin
            n = hold_off_cycles;
            hold_off_cycles = 0;
            repeat (n) begin
               @(negedge clock);
               rsp_chan.ready <= 1'b0;
            end
         end else begin
            stall = pick_gap();
            repeat (stall) begin
               @(negedge clock);
               rsp_chan.ready <= 1'b0;
            end
            @(negedge clock);
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic send_request(input door_request_type rq);
      int gap;
      gap = (burst_left > 0) ? 0 : pick_gap();
      if (burst_left > 0)
         burst_left--;
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid        <= 1'b1;
      req_chan.operation    <= rq.operation;
      req_chan.elapsed_ms   <= rq.elapsed_ms;
      req_chan.beacon_found <= rq.beacon_found;
      req_chan.beacon_rssi  <= rq.beacon_rssi;
      req_chan.path_clear   <= rq.path_clear;
      req_chan.pet_passed   <= rq.pet_passed;
      do
         @(posedge clock);
      while (req_chan.ready !== 1'b1);
   endtask

   task automatic issue(input logic [1:0] op, input int dt, input bit found,
                        input int rssi, input bit clear, input bit pet);
      door_request_type rq;
      rq.operation    = op;
      rq.elapsed_ms   = dt[15:0];
      rq.beacon_found = found;
      rq.beacon_rssi  = rssi[7:0];
      rq.path_clear   = clear;
      rq.pet_passed   = pet;
      send_request(rq);
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (door.pending() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      if (door.pending() != 0)
         door.report($sformatf("%0d responses never arrived", door.pending()));
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index, input int value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value[CSR_DATA_WIDTH-1:0];
      @(posedge clock);
      door.write_reg(index, value[CSR_DATA_WIDTH-1:0]);
   endtask

   task automatic configure(input int open_v, input int close_v, input int travel_v,
                            input int btime_v, input int wtime_v);
      drain();
      write_csr(CSR_OPEN_RSSI, open_v);
      write_csr(CSR_CLOSE_RSSI, close_v);
      write_csr(CSR_TRAVEL_MS, travel_v);
      write_csr(CSR_BEACON_TIMEOUT, btime_v);
      write_csr(CSR_WAIT_TIMEOUT, wtime_v);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cur_travel = travel_v[15:0];
      cur_open   = open_v;
   endtask

   function door_request_type random_request();
      door_request_type rq;
      int k;
      int rssi;
      k = $urandom_range(0, 99);
      if (k < 78)
         rq.operation = OP_TICK;
      else if (k < 87)
         rq.operation = OP_OPEN;
      else if (k < 96)
         rq.operation = OP_CLOSE;
      else
         rq.operation = OP_UNUSED;
      k = $urandom_range(0, 99);
      if (k < 10)
         rq.elapsed_ms = 16'd0;
      else if (k < 18)
         rq.elapsed_ms = 16'hFFFF;
      else if (k < 30)
         rq.elapsed_ms = $urandom;
      else
         rq.elapsed_ms = $urandom_range(0, cur_travel / 3 + 1);
      if ($urandom_range(0, 99) < 30) begin
         rssi = cur_open + $urandom_range(0, 6) - 3;
         if (rssi > 0)
            rssi = 0;
         if (rssi < -128)
            rssi = -128;
      end else begin
         rssi = -$urandom_range(0, 128);
      end
      rq.beacon_rssi  = rssi[7:0];
      rq.beacon_found = ($urandom_range(0, 99) < 55);
      rq.path_clear   = ($urandom_range(0, 99) < 88);
      rq.pet_passed   = ($urandom_range(0, 99) < 15);
      return rq;
   endfunction

   task automatic run_random(input int count);
      repeat (count) send_request(random_request());
   endtask

   initial begin
      #(10_000_000);
      $display("** proximity_door_controller: FAILED **");
      $finish;
   end

   initial begin
      reset                 = 1'b1;
      csr_write_enable      = 1'b0;
      csr_index             = '0;
      csr_write_data        = '0;
      req_chan.valid        = 1'b0;
      req_chan.operation    = OP_TICK;
      req_chan.elapsed_ms   = '0;
      req_chan.beacon_found = 1'b0;
      req_chan.beacon_rssi  = '0;
      req_chan.path_clear   = 1'b1;
      req_chan.pet_passed   = 1'b0;
      steady                = 1'b0;
      burst_left            = 0;
      hold_off_cycles       = 0;
      cur_travel            = TRAVEL_MS_RESET;
      cur_open              = OPEN_RSSI_RESET;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // walk the door through every mode at the reset settings
      issue(OP_UNUSED, 65535, 1, -1, 0, 1);
      issue(OP_CLOSE, 65535, 1, 0, 0, 1);
      issue(OP_TICK, 500, 1, -76, 1, 0);
      issue(OP_TICK, 0, 1, 0, 1, 0);
      issue(OP_OPEN, 0, 0, -128, 1, 0);
      issue(OP_TICK, 4000, 1, 0, 1, 0);
      issue(OP_TICK, 65535, 1, 0, 1, 0);
      issue(OP_OPEN, 0, 0, 0, 1, 0);
      issue(OP_TICK, 1000, 0, -128, 1, 0);
      issue(OP_TICK, 10, 1, 0, 1, 1);
      issue(OP_TICK, 100, 1, 0, 0, 0);
      issue(OP_TICK, 65535, 1, 0, 1, 0);
      issue(OP_TICK, 0, 1, -128, 1, 0);
      issue(OP_TICK, 3000, 1, 0, 1, 0);
      issue(OP_CLOSE, 0, 0, 0, 1, 0);
      issue(OP_TICK, 65535, 1, 0, 1, 0);
      issue(OP_OPEN, 0, 0, 0, 1, 0);
      issue(OP_TICK, 65535, 1, 0, 1, 0);
      issue(OP_TICK, 100, 0, -100, 0, 1);
      issue(OP_OPEN, 0, 0, 0, 1, 0);
      issue(OP_CLOSE, 0, 0, 0, 1, 0);
      issue(OP_TICK, 65535, 1, 0, 1, 0);
      issue(OP_TICK, 1, 1, -75, 1, 0);
      issue(OP_TICK, 20000, 1, 0, 1, 0);
      issue(OP_TICK, 5000, 1, 0, 1, 0);

      configure(-75, -90, 300, 150, 400);
      run_random(185);

      configure(-128, -128, 65535, 65534, 65535);
      run_random(185);

      configure(0, 0, 1, 0, 0);
      steady = 1'b1;
      run_random(185);
      steady = 1'b0;

      configure(-60, -100, 2000, 800, 1500);
      run_random(60);
      // hold off the response side while requests keep coming
      hold_off_cycles = 80;
      burst_left      = 30;
      run_random(125);

      configure(-70, -85, 0, 500, 1000);
      run_random(185);

      configure(-$urandom_range(0, 128), -$urandom_range(0, 128),
                $urandom_range(1, 5000), $urandom_range(0, 3000),
                $urandom_range(0, 6000));
      steady = 1'b1;
      run_random(185);
      steady = 1'b0;

      repeat (2) begin
         configure(-$urandom_range(0, 128), -$urandom_range(0, 128),
                   $urandom_range(1, 5000), $urandom_range(0, 3000),
                   $urandom_range(0, 6000));
         run_random(185);
      end

      drain();
      repeat (10) @(posedge clock);
      if (door.failures == 0)
         $display("** proximity_door_controller: PASSED **");
      else
         $display("** proximity_door_controller: FAILED **");
      $finish;
   end

endmodule
